// ===== sv/pmls_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the multilevel scheduler.
package pmls_pkg;

  // Operation codes
  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_TAKE = 2'd1;
  localparam logic [1:0] OP_TEST = 2'd2;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_LEVEL_COUNT      = 2'd0;
  localparam logic [1:0] REG_QUANTUM          = 2'd1;
  localparam logic [1:0] REG_PREEMPT_BY_LEVEL = 2'd2;

  // Register reset values
  localparam logic [3:0]  LEVEL_COUNT_RST = 4'd4;
  localparam logic [15:0] QUANTUM_RST     = 16'hFFFF;
  localparam logic        PREEMPT_RST     = 1'b1;

  // Dynamic priority of a process whose slice ran out
  localparam logic signed [3:0] DP_EXHAUSTED = -4'sd1;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [5:0]        process_id;
    logic signed [3:0] dynamic_priority;
    logic [3:0]        base_priority;
    logic [15:0]       burst_left;
    logic              check_quantum;
  } cmd_item_t;

  typedef struct packed {
    logic       found;
    logic [5:0] chosen_id;
    logic [2:0] level_out;
    logic       preempt;
    logic       rejected;
  } res_item_t;

  typedef struct packed {
    logic [3:0]  level_count;
    logic [15:0] quantum;
    logic        preempt_by_level;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic load;
  } ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

// ===== sv/pmls_chan_if.sv =====
`timescale 1ns / 1ps
// Valid/ready item channel carrying one payload struct.
interface pmls_chan_if #(parameter type item_t = logic);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/preemptive_multilevel_scheduler_core.sv =====
`timescale 1ns / 1ps
// Top level of the active/expired multilevel priority scheduler.
//
// Usage:
//   cmd: valid/ready channel of command items (add, take next, preempt test).
//   res: valid/ready channel with exactly one result item per command item.
//   APB port: level_count at 0x0, quantum at 0x4, preempt_by_level at 0x8;
//   write only while no command is in flight.
// Timing: a command is accepted in the idle state, executed in the next
// cycle (one FIFO memory access plus the level search) and its result is
// loaded into the output register in the cycle after, once that register is
// free. A new command is accepted only after the previous result has been
// loaded. The load state follows execution because the read of the FIFO
// memory is registered.
// Stalls: a waiting result sits in the output register while the next
// command is accepted and executed; only its delivery waits for res.ready.
// Reset (rst, synchronous): all FIFOs empty, bank 0 active, registers at
// their defaults, no result pending. The FIFO memory needs no clearing.
module preemptive_multilevel_scheduler_core #(
  parameter int LEVELS      = 8,
  parameter int QUEUE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  pmls_chan_if.sink   cmd,
  pmls_chan_if.source res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pmls_pkg::*;

  ctl_t ctl;
  sts_t sts;
  cfg_t cfg;

  pmls_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pmls_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .sts       (sts),
    .cmd_ready (cmd.ready),
    .ctl       (ctl)
  );

  pmls_dpath #(
    .LEVELS      (LEVELS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd_data  (cmd.data),
    .ctl       (ctl),
    .cfg       (cfg),
    .sts       (sts),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_data  (res.data)
  );

endmodule

// ===== sv/pmls_cfg.sv =====
`timescale 1ns / 1ps
// APB-style configuration registers of the scheduler.
module pmls_cfg (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output pmls_pkg::cfg_t     cfg
);
  import pmls_pkg::*;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[3:2];

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.level_count      <= LEVEL_COUNT_RST;
      cfg.quantum          <= QUANTUM_RST;
      cfg.preempt_by_level <= PREEMPT_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_LEVEL_COUNT:      cfg.level_count      <= pwdata[3:0];
        REG_QUANTUM:          cfg.quantum          <= pwdata[15:0];
        REG_PREEMPT_BY_LEVEL: cfg.preempt_by_level <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_LEVEL_COUNT:      prdata = {28'd0, cfg.level_count};
      REG_QUANTUM:          prdata = {16'd0, cfg.quantum};
      REG_PREEMPT_BY_LEVEL: prdata = {31'd0, cfg.preempt_by_level};
      default:              prdata = '0;
    endcase
  end

endmodule

// ===== sv/pmls_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencing state machine of the scheduler: accept, execute, deliver.
module pmls_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  pmls_pkg::sts_t sts,
  output logic           cmd_ready,
  output pmls_pkg::ctl_t ctl
);
  import pmls_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // Commands
  assign cmd_ready   = (state == S_IDLE);
  assign ctl.capture = cmd_ready & cmd_valid;
  assign ctl.exec    = (state == S_EXEC);
  assign ctl.load    = (state == S_LOAD) & sts.out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (cmd_valid) state_next = S_EXEC;
      S_EXEC: state_next = S_LOAD;
      S_LOAD: if (sts.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== sv/pmls_dpath.sv =====
`timescale 1ns / 1ps
// Scheduler datapath: FIFO pointers and counts, FIFO memory, level search, result register.
module pmls_dpath #(
  parameter int LEVELS      = 8,
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  pmls_pkg::cmd_item_t cmd_data,
  input  pmls_pkg::ctl_t      ctl,
  input  pmls_pkg::cfg_t      cfg,
  output pmls_pkg::sts_t      sts,
  output logic                res_valid,
  input  logic                res_ready,
  output pmls_pkg::res_item_t res_data
);
  import pmls_pkg::*;

  localparam int LW = $clog2(LEVELS);
  localparam int FW = LW + 1;
  localparam int NF = 1 << FW;
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int MD = NF << PW;
  localparam logic [CW-1:0] FULL     = CW'(QUEUE_DEPTH);
  localparam logic [PW-1:0] LAST     = PW'(QUEUE_DEPTH - 1);
  localparam logic [4:0]    LEVELS_V = 5'(LEVELS);

  cmd_item_t     op_q;
  logic [PW-1:0] head [NF];
  logic [PW-1:0] tail [NF];
  logic [CW-1:0] fill [NF];
  logic          bank;
  logic [5:0]    mem [MD];
  logic [5:0]    mem_q;

  logic          r_found;
  logic [LW-1:0] r_level;
  logic          r_preempt;
  logic          r_rejected;

  logic [4:0]        n_lv;
  logic [LEVELS-1:0] act_ne;
  logic [LEVELS-1:0] oth_ne;
  logic [LEVELS-1:0] higher;
  logic [LW-1:0]     act_lvl;
  logic [LW-1:0]     oth_lvl;
  logic              act_any;
  logic              oth_any;
  logic              is_add;
  logic              is_take;
  logic              is_test;
  logic              add_ok;
  logic [LW-1:0]     add_lvl;
  logic              add_bank;
  logic [FW-1:0]     add_f;
  logic              add_full;
  logic              push;
  logic [FW-1:0]     take_f;
  logic [LW-1:0]     take_lvl;
  logic              take_found;
  logic              pop;
  logic              pre;

  // Item capture
  always_ff @(posedge clk) begin
    if (ctl.capture) op_q <= cmd_data;
  end

  assign is_add  = (op_q.opcode == OP_ADD);
  assign is_take = (op_q.opcode == OP_TAKE);
  assign is_test = (op_q.opcode == OP_TEST);

  // Levels in use: zero means one, saturate at LEVELS
  always_comb begin
    if (cfg.level_count == 4'd0) n_lv = 5'd1;
    else if ({1'b0, cfg.level_count} > LEVELS_V) n_lv = LEVELS_V;
    else n_lv = {1'b0, cfg.level_count};
  end

  // Per-level non-empty flags of both banks, and levels above the tested priority
  always_comb begin
    for (int l = 0; l < LEVELS; l++) begin
      act_ne[l] = (5'(l) < n_lv) && (fill[{bank, LW'(l)}] != '0);
      oth_ne[l] = (5'(l) < n_lv) && (fill[{~bank, LW'(l)}] != '0);
      higher[l] = op_q.dynamic_priority[3] ||
                  (5'(l) > {1'b0, op_q.dynamic_priority[3:0]});
    end
  end

  // Highest non-empty level in each bank
  always_comb begin
    act_lvl = '0;
    oth_lvl = '0;
    for (int l = 0; l < LEVELS; l++) begin
      if (act_ne[l]) act_lvl = LW'(l);
      if (oth_ne[l]) oth_lvl = LW'(l);
    end
  end

  assign act_any = |act_ne;
  assign oth_any = |oth_ne;

  // Add: target level and bank; exhausted slice goes to the expired bank
  always_comb begin
    add_ok   = 1'b0;
    add_lvl  = '0;
    add_bank = bank;
    if (op_q.dynamic_priority == DP_EXHAUSTED) begin
      if (op_q.base_priority != 4'd0 && {1'b0, op_q.base_priority} <= n_lv) begin
        add_ok   = 1'b1;
        add_lvl  = LW'(op_q.base_priority - 4'd1);
        add_bank = ~bank;
      end
    end else if (!op_q.dynamic_priority[3] &&
                 {1'b0, op_q.dynamic_priority[3:0]} < n_lv) begin
      add_ok  = 1'b1;
      add_lvl = LW'(op_q.dynamic_priority[3:0]);
    end
  end

  assign add_f    = {add_bank, add_lvl};
  assign add_full = (fill[add_f] == FULL);
  assign push     = is_add & add_ok & ~add_full;

  // Take: active bank first, else the other bank after the swap
  assign take_lvl   = act_any ? act_lvl : oth_lvl;
  assign take_f     = act_any ? {bank, act_lvl} : {~bank, oth_lvl};
  assign take_found = act_any | oth_any;
  assign pop        = is_take & take_found;

  // Preempt test
  assign pre = (cfg.preempt_by_level & (|(act_ne & higher))) |
               (op_q.check_quantum & (op_q.burst_left > cfg.quantum));

  // FIFO pointers, counts and bank select
  always_ff @(posedge clk) begin
    if (rst) begin
      bank <= 1'b0;
      for (int f = 0; f < NF; f++) begin
        head[f] <= '0;
        tail[f] <= '0;
        fill[f] <= '0;
      end
    end else if (ctl.exec) begin
      if (push) begin
        tail[add_f] <= (tail[add_f] == LAST) ? '0 : tail[add_f] + PW'(1);
        fill[add_f] <= fill[add_f] + CW'(1);
      end
      if (pop) begin
        head[take_f] <= (head[take_f] == LAST) ? '0 : head[take_f] + PW'(1);
        fill[take_f] <= fill[take_f] - CW'(1);
      end
      if (is_take && !act_any) bank <= ~bank;
    end
  end

  // FIFO memory: write port
  always_ff @(posedge clk) begin
    if (ctl.exec && push) mem[{add_f, tail[add_f]}] <= op_q.process_id;
  end

  // FIFO memory: registered read port
  always_ff @(posedge clk) begin
    if (ctl.exec && pop) mem_q <= mem[{take_f, head[take_f]}];
  end

  // Result fields held until the output register is free
  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      r_found    <= pop;
      r_preempt  <= is_test & pre;
      r_rejected <= is_add & (~add_ok | add_full);
      if (is_add && add_ok) r_level <= add_lvl;
      else if (pop) r_level <= take_lvl;
      else r_level <= '0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctl.load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      res_data.found     <= r_found;
      res_data.chosen_id <= r_found ? mem_q : 6'd0;
      res_data.level_out <= 3'(r_level);
      res_data.preempt   <= r_preempt;
      res_data.rejected  <= r_rejected;
    end
  end

  assign sts.out_free = ~res_valid | res_ready;

  // A pop lowers the count of the FIFO it took from by one
  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    ctl.exec && pop |=> fill[$past(take_f)] == $past(fill[take_f]) - CW'(1))
    else $error("pop did not decrement fill count");

  // An empty active bank on take swaps the banks
  a_bank_swap: assert property (@(posedge clk) disable iff (rst)
    ctl.exec && is_take && !act_any |=> bank != $past(bank))
    else $error("bank swap missing");

  // Loading the result always presents it on the next cycle
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    ctl.load |=> res_valid)
    else $error("loaded result not valid");

  // No process number without a found process
  a_id_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_data.found |-> res_data.chosen_id == 6'd0)
    else $error("chosen_id set without found");

endmodule
